// File: rtl/bdet_pkg.sv
package bdet_pkg;

  // Width of the saturating tick counters
  localparam int COUNT_WIDTH = 24;

  // Widths of the tick period register, the reported durations and the product
  localparam int PERIOD_W = 8;
  localparam int TIME_W   = 32;
  localparam int PROD_W   = COUNT_WIDTH + PERIOD_W;

  // Configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = CFG_IDX_W'(1);

  // Reset values of the configuration registers
  localparam logic                RESET_ACTIVE_LOW  = 1'b1;
  localparam logic [PERIOD_W-1:0] RESET_TICK_PERIOD = PERIOD_W'(10);

  typedef logic [COUNT_WIDTH-1:0] ticks_t;
  typedef logic [PERIOD_W-1:0]    period_t;
  typedef logic [TIME_W-1:0]      time_val_t;

  localparam ticks_t TICKS_MAX = '1;

  // Steps of the change verifier
  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_CONFIRM,
    STEP_RECHECK
  } step_t;

  // Duration in time units, saturated to the result width.
  function automatic time_val_t scale_time(ticks_t ticks, period_t period);
    logic [63:0] prod;
    prod = 64'(PROD_W'(ticks) * PROD_W'(period));
    return (|prod[63:TIME_W]) ? '1 : prod[TIME_W-1:0];
  endfunction

endpackage

// File: rtl/bdet_if.sv
// Poll tick request channel
interface bdet_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic clear_pressed_event;
  logic clear_released_event;

  modport source (output valid, pin_level, clear_pressed_event, clear_released_event,
                  input ready);
  modport sink   (input valid, pin_level, clear_pressed_event, clear_released_event,
                  output ready);
endinterface

// Result channel
interface bdet_out_if;
  logic                  valid;
  logic                  ready;
  logic                  is_pressed;
  logic                  pressed_event;
  logic                  released_event;
  bdet_pkg::time_val_t   pressed_time;
  bdet_pkg::time_val_t   released_time;

  modport source (output valid, is_pressed, pressed_event, released_event,
                  pressed_time, released_time, input ready);
  modport sink   (input valid, is_pressed, pressed_event, released_event,
                  pressed_time, released_time, output ready);
endinterface

// Configuration write channel
interface bdet_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bdet_pkg::CFG_IDX_W-1:0]  index;
  logic [bdet_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/button_debounce_event_timer.sv
// Push-button debouncer with sticky press/release events and duration timers.
// One instance serves one pin.
// in_ch:  one request per poll tick, carrying the raw pin level and two
//         requests to clear the sticky event flags (clears act first).
// out_ch: one result per request: debounced state, both event flags and the
//         pressed and released durations (tick count times tick period).
// cfg_ch: register writes (index 0 polarity, index 1 tick period); always
//         ready, and to be used only while no request is in flight.
// An accepted request is stored in the state registers, and the result
// register takes it from them when it is free; the duration multipliers
// sit between the state registers and the result register.
// Throughput: one request per cycle while out_ch does not stall.
// A request is taken while a finished result still waits, since the state
// registers and the result register form two stages; only when both are
// held by a stalled receiver does in_ch.ready drop.
// Reset clears the verifier, the flags and the counters, sets polarity to
// active low and the tick period to 10, and empties both stages.
module button_debounce_event_timer (
  input  logic              clk,
  input  logic              rst_n,
  bdet_cfg_if.sink          cfg_ch,
  bdet_in_if.sink           in_ch,
  bdet_out_if.source        out_ch
);

  // Configuration registers
  logic                  active_low_r;
  bdet_pkg::period_t     tick_period_r;

  // Verifier and event state
  bdet_pkg::step_t       step_r, step_nxt;
  logic                  last_r, last_nxt;
  logic                  cand_r, cand_nxt;
  logic                  stable_r, stable_nxt;
  logic                  press_flag_r, press_flag_nxt;
  logic                  release_flag_r, release_flag_nxt;
  bdet_pkg::ticks_t      press_ticks_r, press_ticks_nxt;
  bdet_pkg::ticks_t      release_ticks_r, release_ticks_nxt;

  // Handshake control
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  s2_free;
  logic                  in_acc;

  // Result register
  logic                  out_is_pressed_r;
  logic                  out_pressed_event_r;
  logic                  out_released_event_r;
  bdet_pkg::time_val_t   out_pressed_time_r;
  bdet_pkg::time_val_t   out_released_time_r;

  // Verifier intermediate values
  logic                  sample;
  logic                  differs;
  logic                  change_ok;
  bdet_pkg::ticks_t      press_base;
  bdet_pkg::ticks_t      release_base;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r  <= bdet_pkg::RESET_ACTIVE_LOW;
      tick_period_r <= bdet_pkg::RESET_TICK_PERIOD;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bdet_pkg::REG_ACTIVE_LOW:  active_low_r  <= cfg_ch.data[0];
        bdet_pkg::REG_TICK_PERIOD: tick_period_r <= cfg_ch.data[bdet_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Two-stage handshake: the state registers hold a request until the
  // result register can take it.
  assign s2_free      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || s2_free;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s2_free ? 1'b0 : s1_valid_r);
    out_valid_nxt = s2_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Verifier: a change is taken only after it has been seen on consecutive polls.
  always_comb begin
    sample           = in_ch.pin_level ^ active_low_r;
    differs          = (sample != last_r);
    change_ok        = 1'b0;
    step_nxt         = step_r;
    last_nxt         = last_r;
    cand_nxt         = cand_r;
    stable_nxt       = stable_r;
    press_flag_nxt   = press_flag_r & ~in_ch.clear_pressed_event;
    release_flag_nxt = release_flag_r & ~in_ch.clear_released_event;

    unique case (step_r)
      bdet_pkg::STEP_IDLE: begin
        if (differs) begin
          cand_nxt = sample;
          step_nxt = bdet_pkg::STEP_CONFIRM;
        end
      end
      bdet_pkg::STEP_CONFIRM: begin
        if (differs && sample == cand_r) begin
          change_ok  = 1'b1;
          last_nxt   = sample;
          stable_nxt = sample;
          step_nxt   = bdet_pkg::STEP_IDLE;
          if (sample) begin
            press_flag_nxt = 1'b1;
          end else begin
            release_flag_nxt = 1'b1;
          end
        end else begin
          cand_nxt = sample;
          step_nxt = bdet_pkg::STEP_RECHECK;
        end
      end
      bdet_pkg::STEP_RECHECK: begin
        if (differs && sample == cand_r) begin
          step_nxt = bdet_pkg::STEP_CONFIRM;
        end else begin
          last_nxt = sample;
          cand_nxt = sample;
          step_nxt = bdet_pkg::STEP_IDLE;
        end
      end
      default: step_nxt = bdet_pkg::STEP_IDLE;
    endcase
  end

  // Duration counters: an accepted change restarts its counter, then the
  // counter of the stable state advances and saturates.
  always_comb begin
    press_base        = (change_ok && sample)  ? '0 : press_ticks_r;
    release_base      = (change_ok && !sample) ? '0 : release_ticks_r;
    press_ticks_nxt   = press_base;
    release_ticks_nxt = release_base;
    if (stable_nxt) begin
      if (press_base != bdet_pkg::TICKS_MAX) begin
        press_ticks_nxt = press_base + bdet_pkg::ticks_t'(1);
      end
    end else begin
      if (release_base != bdet_pkg::TICKS_MAX) begin
        release_ticks_nxt = release_base + bdet_pkg::ticks_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= bdet_pkg::STEP_IDLE;
      last_r          <= 1'b0;
      cand_r          <= 1'b0;
      stable_r        <= 1'b0;
      press_flag_r    <= 1'b0;
      release_flag_r  <= 1'b0;
      press_ticks_r   <= '0;
      release_ticks_r <= '0;
    end else if (in_acc) begin
      step_r          <= step_nxt;
      last_r          <= last_nxt;
      cand_r          <= cand_nxt;
      stable_r        <= stable_nxt;
      press_flag_r    <= press_flag_nxt;
      release_flag_r  <= release_flag_nxt;
      press_ticks_r   <= press_ticks_nxt;
      release_ticks_r <= release_ticks_nxt;
    end
  end

  // Result register: scale the held counts by the tick period.
  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      out_is_pressed_r     <= stable_r;
      out_pressed_event_r  <= press_flag_r;
      out_released_event_r <= release_flag_r;
      out_pressed_time_r   <= bdet_pkg::scale_time(press_ticks_r, tick_period_r);
      out_released_time_r  <= bdet_pkg::scale_time(release_ticks_r, tick_period_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_pressed     = out_is_pressed_r;
  assign out_ch.pressed_event  = out_pressed_event_r;
  assign out_ch.released_event = out_released_event_r;
  assign out_ch.pressed_time   = out_pressed_time_r;
  assign out_ch.released_time  = out_released_time_r;

endmodule

// File: rtl/bdet_checker.sv
module bdet_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                is_pressed,
  input logic                pressed_event,
  input logic                released_event,
  input bdet_pkg::time_val_t pressed_time,
  input bdet_pkg::time_val_t released_time
);

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // A request accepted with the result stage empty leads to a valid result once it has passed the state registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("result missing two cycles after request");

  // A result only appears for an accepted request that has passed through the state registers.
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared with no request behind it");

  // Requests are refused only while a result is waiting.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request refused with no result waiting");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(is_pressed)
      && $stable(pressed_event) && $stable(released_event)
      && $stable(pressed_time) && $stable(released_time))
    else $error("stalled result changed");

endmodule

bind button_debounce_event_timer bdet_checker u_bdet_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .is_pressed     (out_ch.is_pressed),
  .pressed_event  (out_ch.pressed_event),
  .released_event (out_ch.released_event),
  .pressed_time   (out_ch.pressed_time),
  .released_time  (out_ch.released_time)
);
